// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
// clocked on clk, disabled while rst is high; empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/rcpwm_pkg.sv =====
`timescale 1ns / 1ps
// beat types, channel kind codes and mapping constants of the rc pulse mapper
// no dependencies
package rcpwm_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] chan_pulse;
    logic [11:0] arm_pulse;
  } in_item_t;

  typedef struct packed {
    logic [15:0] forward_level;
    logic [15:0] reverse_level;
    logic        switch_out;
  } out_item_t;

  // channel kinds
  localparam logic [1:0] OP_BIDIR  = 2'd0;
  localparam logic [1:0] OP_UNIDIR = 2'd1;
  localparam logic [1:0] OP_SWITCH = 2'd2;

  // register byte addresses
  localparam logic [2:0] REG_PWM_WRAP = 3'd0;

  localparam logic [15:0] PWM_WRAP_RESET = 16'd19999;

  localparam logic [11:0] ARM_MIN    = 12'd1400;
  localparam logic [11:0] PULSE_MIN  = 12'd1000;
  localparam logic [11:0] PULSE_MAX  = 12'd2000;
  localparam logic [11:0] PULSE_MID  = 12'd1500;
  localparam logic [11:0] PULSE_2MID = 12'd3000;
  localparam logic [9:0]  THR_DEADBAND = 10'd10;
  localparam logic [16:0] MOTOR_START  = 17'd6600;

  // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT, exact for x below 2^26
  localparam logic [26:0] RECIP_1000  = 27'd68719477;
  localparam int          RECIP_SHIFT = 36;

endpackage

// ===== hw/rtl/rc_pulse_to_motor_pwm_unit.sv =====
`timescale 1ns / 1ps
// rc pulse to motor pwm level mapper, four-register pipeline
// depends on rcpwm_pkg and assert_macros.svh
//
// usage
//   input channel: in_valid / in_stall / in_data, one beat per channel pulse
//   (kind, pulse width, arm pulse); output channel: out_valid / out_stall /
//   out_data with forward level, reverse level and switch output.
//   one result beat per input beat, in order.
//   the accepting edge loads the input register, then the throttle*span
//   product, the reciprocal multiply for the divide by 1000 and the result
//   register are registered in that order. throughput: one beat per cycle
//   while out_stall is low; each multiplier stage holds one beat.
//   a stalled receiver holds the result register; stages behind it keep
//   filling until every stage is occupied, then in_stall rises.
//   reset clears all stage valids and sets pwm_wrap to 19999.
//   pwm_wrap sits at byte address 0 of the apb port; write it only while
//   the pipeline is empty.
module rc_pulse_to_motor_pwm_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rcpwm_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rcpwm_pkg::out_item_t  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import rcpwm_pkg::*;

`include "assert_macros.svh"

  logic [15:0] pwm_wrap;

  // stage 1: input register
  logic        s1_valid;
  in_item_t    s1_item;
  // stage 2: throttle * span
  logic        s2_valid;
  logic [25:0] s2_prod;
  logic        s2_fwd_en;
  logic        s2_rev_en;
  logic        s2_sw;
  // stage 3: quotient by 1000
  logic        s3_valid;
  logic [16:0] s3_quo;
  logic        s3_fwd_en;
  logic        s3_rev_en;
  logic        s3_sw;

  logic adv_out, adv3, adv2, adv1;

  logic [10:0] p_cl;
  logic [11:0] p_dbl;
  logic [11:0] thr_wide;
  logic [9:0]  throttle;
  logic        forward;
  logic        motor_on;
  logic        thr_ok;
  logic [16:0] top;
  logic [15:0] span;
  logic [25:0] prod_next;
  logic [52:0] recip_prod;
  logic [16:0] lvl;
  logic [15:0] lvl_sat;
  out_item_t   out_next;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_wrap <= PWM_WRAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_PWM_WRAP[2]) begin
      pwm_wrap <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PWM_WRAP[2]) begin
      prdata = {16'd0, pwm_wrap};
    end
  end

  // stage advance chain, bubbles collapse behind a stalled output
  assign adv_out  = !out_valid || !out_stall;
  assign adv3     = !s3_valid || adv_out;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= in_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
      if (adv_out) begin
        out_valid <= s3_valid;
      end
    end
  end

  // stage 1 logic: clamp, throttle, span, product
  always_comb begin
    if (s1_item.chan_pulse < PULSE_MIN) begin
      p_cl = PULSE_MIN[10:0];
    end else if (s1_item.chan_pulse > PULSE_MAX) begin
      p_cl = PULSE_MAX[10:0];
    end else begin
      p_cl = s1_item.chan_pulse[10:0];
    end
    p_dbl = {p_cl, 1'b0};

    if (s1_item.op == OP_UNIDIR) begin
      thr_wide = {1'b0, p_cl} - PULSE_MIN;
      forward  = 1'b1;
    end else if ({1'b0, p_cl} > PULSE_MID) begin
      thr_wide = p_dbl - PULSE_2MID;
      forward  = 1'b1;
    end else begin
      thr_wide = PULSE_2MID - p_dbl;
      forward  = 1'b0;
    end
    throttle = thr_wide[9:0];
    thr_ok   = throttle >= THR_DEADBAND;
    motor_on = (s1_item.op == OP_BIDIR || s1_item.op == OP_UNIDIR) &&
               s1_item.arm_pulse >= ARM_MIN;

    top  = {1'b0, pwm_wrap} + 17'd1;
    span = (top > MOTOR_START) ? 16'(top - MOTOR_START) : 16'd0;
    prod_next = 26'(throttle) * 26'(span);
  end

  // stage 2 reciprocal multiply; stage 3 logic: offset and saturate, route to at most one output
  assign recip_prod = 53'(s2_prod) * 53'(RECIP_1000);
  assign lvl        = MOTOR_START + s3_quo;
  assign lvl_sat    = lvl[16] ? 16'hFFFF : lvl[15:0];

  always_comb begin
    out_next.forward_level = s3_fwd_en ? lvl_sat : 16'd0;
    out_next.reverse_level = s3_rev_en ? lvl_sat : 16'd0;
    out_next.switch_out    = s3_sw;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_item <= in_data;
    end
    if (adv2) begin
      s2_prod   <= prod_next;
      s2_fwd_en <= motor_on && thr_ok && forward;
      s2_rev_en <= motor_on && thr_ok && !forward;
      s2_sw     <= (s1_item.op == OP_SWITCH) && (s1_item.chan_pulse > PULSE_MID);
    end
    if (adv3) begin
      s3_quo    <= recip_prod[RECIP_SHIFT +: 17];
      s3_fwd_en <= s2_fwd_en;
      s3_rev_en <= s2_rev_en;
      s3_sw     <= s2_sw;
    end
    if (adv_out) begin
      out_data <= out_next;
    end
  end

  `ASSERT_IMPLY(a_one_direction, out_valid,
                out_data.forward_level == 16'd0 || out_data.reverse_level == 16'd0)
  `ASSERT_IMPLY(a_switch_no_drive, out_valid && out_data.switch_out,
                out_data.forward_level == 16'd0 && out_data.reverse_level == 16'd0)
  `ASSERT_IMPLY(a_fwd_min_level, out_valid && out_data.forward_level != 16'd0,
                out_data.forward_level >= MOTOR_START[15:0])
  `ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, s1_valid)

endmodule
